// ===== hdl/ring_buffer_deque_core_assert.svh =====
// Assertion macros for the ring buffer deque core.
`ifndef RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`define RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RBDQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rbdq assertion failed");
`define RBDQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rbdq assertion failed");
`else
`define RBDQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RBDQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/rbdq_pkg.sv =====
// Shared types and constants for the ring buffer deque core.
`default_nettype none
package rbdq_pkg;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CODE_W  = 2;

    typedef enum logic [CODE_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } rbdq_action_t;

    typedef enum logic [CODE_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } rbdq_status_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } rbdq_mem_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/rbdq_store.sv =====
// Entry store: single-port synchronous memory with a registered read.
`default_nettype none
module rbdq_store
    import rbdq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire rbdq_mem_cmd_t            cmd,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [VALUE_W-1:0]       wdata,
    output logic      [VALUE_W-1:0]       rdata
);
    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[addr] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== hdl/ring_buffer_deque_core.sv =====
// Ring buffer deque core: top level with pointer control and result stage.
//
// Usage:
//   Input channel s_*: s_tuser carries the action (push front, push back,
//   pop front, pop back), s_tdata the value to push (ignored on pops).
//   Result channel m_*: one transaction per input transaction, in order.
//   m_tdata carries the popped value (zero on pushes and refusals) and the
//   entry count after the action; m_tuser carries the status code.
//   A result passes through the first stage (with the memory read register)
//   and then the output register.
//   Throughput: one transaction per cycle while the receiver does not stall,
//   set by the single memory port, which each action uses at most once.
//   A push onto a full deque returns the full status, a pop on an empty
//   deque returns the empty status; neither changes the contents.
//   Reset empties the deque and drops results not yet taken; the memory
//   is not cleared, as no entry is read before it is written.
//   When the receiver stalls, the output register and the stage behind it
//   fill and then s_tready drops until m_tready returns.
`default_nettype none
`include "ring_buffer_deque_core_assert.svh"
module ring_buffer_deque_core
    import rbdq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [31:0] push_value
    input  wire logic [1:0]  s_tuser,  // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,  // [31:0] pop_value, [35:32] fill_count, [39:36] zero
    output logic      [1:0]  m_tuser   // [1:0] status
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] occ_reg, occ_next;

    logic               p1_valid_reg;
    rbdq_status_t       p1_status_reg, p1_status_next;
    logic [COUNT_W-1:0] p1_count_reg;
    logic               p1_rd_reg;

    logic               m_valid_reg;
    rbdq_status_t       m_status_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [VALUE_W-1:0] m_value_reg;

    rbdq_action_t       act;
    rbdq_mem_cmd_t      cmd;
    logic [AW-1:0]      mem_addr;
    logic [VALUE_W-1:0] mem_rdata;
    logic               acc;
    logic               p1_adv;
    logic               is_full;
    logic               is_empty;
    logic [CW+COUNT_W-1:0] occ_ext;

    assign act      = rbdq_action_t'(s_tuser);
    assign is_full  = (occ_reg == FULL_CNT);
    assign is_empty = (occ_reg == '0);
    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        p1_status_next = ST_OK;
        cmd            = '0;
        mem_addr       = head_reg;
        unique case (act)
            ACT_PUSH_FRONT: begin
                mem_addr = idx_dec(head_reg);
                if (is_full) begin
                    p1_status_next = ST_FULL;
                end else begin
                    head_next = idx_dec(head_reg);
                    occ_next  = occ_reg + 1'b1;
                    cmd.wr    = acc;
                end
            end
            ACT_PUSH_BACK: begin
                mem_addr = tail_reg;
                if (is_full) begin
                    p1_status_next = ST_FULL;
                end else begin
                    tail_next = idx_inc(tail_reg);
                    occ_next  = occ_reg + 1'b1;
                    cmd.wr    = acc;
                end
            end
            ACT_POP_FRONT: begin
                mem_addr = head_reg;
                if (is_empty) begin
                    p1_status_next = ST_EMPTY;
                end else begin
                    head_next = idx_inc(head_reg);
                    occ_next  = occ_reg - 1'b1;
                    cmd.rd    = acc;
                end
            end
            ACT_POP_BACK: begin
                mem_addr = idx_dec(tail_reg);
                if (is_empty) begin
                    p1_status_next = ST_EMPTY;
                end else begin
                    tail_next = idx_dec(tail_reg);
                    occ_next  = occ_reg - 1'b1;
                    cmd.rd    = acc;
                end
            end
            default: begin
                p1_status_next = ST_OK;
            end
        endcase
    end

    assign occ_ext = {{COUNT_W{1'b0}}, occ_next};

    rbdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .cmd   (cmd),
        .addr  (mem_addr),
        .wdata (s_tdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (acc) begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
            if (acc) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            p1_status_reg <= p1_status_next;
            p1_count_reg  <= occ_ext[COUNT_W-1:0];
            p1_rd_reg     <= cmd.rd;
        end
        if (p1_adv) begin
            m_status_reg <= p1_status_reg;
            m_count_reg  <= p1_count_reg;
            m_value_reg  <= p1_rd_reg ? mem_rdata : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

    `RBDQ_ASSERT_IMP(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= FULL_CNT)
    `RBDQ_ASSERT_IMP(a_ptr_meet, aclk, aresetn, is_empty || is_full, head_reg == tail_reg)
    `RBDQ_ASSERT_NXT(a_pop_empty, aclk, aresetn,
        acc && is_empty && (act == ACT_POP_FRONT || act == ACT_POP_BACK),
        p1_status_reg == ST_EMPTY && !p1_rd_reg)
    `RBDQ_ASSERT_NXT(a_p1_hold, aclk, aresetn, p1_valid_reg && !p1_adv, p1_valid_reg)
endmodule
`default_nettype wire

// ===== verif/ring_buffer_deque_checker.sv =====
`timescale 1ns / 1ps
// Deque result checker: tracks deque contents from accepted transactions and compares results.
module ring_buffer_deque_checker
    import rbdq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] push_value
    input  logic [1:0]  s_tuser,  // [1:0] action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,  // [31:0] pop_value, [35:32] fill_count, [39:36] zero
    input  logic [1:0]  m_tuser,  // [1:0] status
    output int          mismatch_count,
    output int          results_pending
);
    localparam int unsigned IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        rbdq_status_t       status;
        logic [COUNT_W-1:0] fill;
    } deque_result_t;

    logic [VALUE_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]   front_idx;
    logic [IDX_W-1:0]   back_idx;
    int unsigned        held;
    deque_result_t      awaited_results [$];

    function automatic logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1);
    endfunction

    function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1);
    endfunction

    function automatic deque_result_t apply_action(rbdq_action_t act, logic [VALUE_W-1:0] val);
        deque_result_t r;
        r.value  = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (act == ACT_PUSH_FRONT) begin
                    front_idx        = step_down(front_idx);
                    slots[front_idx] = val;
                    held++;
                end else begin
                    slots[back_idx] = val;
                    back_idx        = step_up(back_idx);
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (act == ACT_POP_FRONT) begin
                    r.value   = slots[front_idx];
                    front_idx = step_up(front_idx);
                    held--;
                end else begin
                    back_idx = step_down(back_idx);
                    r.value  = slots[back_idx];
                    held--;
                end
            end
        endcase
        r.fill = COUNT_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [39:0] seen, logic [39:0] wanted);
        mismatch_count++;
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, seen, wanted);
    endtask

    always @(posedge aclk) begin
        deque_result_t want;
        if (!aresetn) begin
            front_idx = '0;
            back_idx  = '0;
            held      = 0;
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                    apply_action(rbdq_action_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("pop_value", 40'(m_tdata[31:0]), 40'(want.value));
                    if (m_tdata[35:32] !== want.fill)
                        report_mismatch("fill_count", 40'(m_tdata[35:32]), 40'(want.fill));
                    if (m_tdata[39:36] !== 4'd0)
                        report_mismatch("tdata padding", 40'(m_tdata[39:36]), '0);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 40'(m_tuser), 40'(want.status));
                end
            end
        end
        results_pending <= awaited_results.size();
    end
endmodule

// ===== verif/ring_buffer_deque_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the ring buffer deque core: clock, reset, stimulus and verdict.
module ring_buffer_deque_core_test
    import rbdq_pkg::*;
;
    localparam int unsigned DEPTH        = 8;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned CALM_ITEMS   = 80;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int          mismatch_count;
    int          results_pending;
    int unsigned sent_count = 0;
    int unsigned idle_pct   = 20;
    int unsigned push_bias  = 50;
    bit          calm       = 1'b0;

    ring_buffer_deque_core #(.DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ring_buffer_deque_checker #(.DEPTH(DEPTH)) deque_scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_action(rbdq_action_t act, logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        if (!calm && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            s_tuser  <= 2'($urandom());
            repeat ($urandom_range(17, 1)) @(posedge aclk);
        end
    endtask

    // receiver: random stalls, one long hold-off to back up the pipeline
    initial begin
        bit long_hold_done;
        long_hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && sent_count >= 40) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (64) @(posedge aclk);
            end else if (calm || $urandom_range(3) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(24, 1)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge aclk);
            end
        end
    end

    initial begin
        int unsigned  drain_cycles;
        rbdq_action_t act;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty refusals, wrap on both ends, fill, full refusals, drain
        send_action(ACT_POP_FRONT, $urandom());
        send_action(ACT_POP_BACK, $urandom());
        send_action(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        send_action(ACT_PUSH_BACK, 32'h8000_0000);
        send_action(ACT_POP_BACK, $urandom());
        send_action(ACT_POP_BACK, $urandom());
        send_action(ACT_PUSH_FRONT, 32'h0000_0000);
        send_action(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_action(ACT_PUSH_BACK, 32'hAAAA_AAAA);
        send_action(ACT_PUSH_BACK, 32'h5555_5555);
        send_action(ACT_PUSH_FRONT, 32'h0000_0001);
        send_action(ACT_PUSH_BACK, 32'h0000_0002);
        send_action(ACT_PUSH_FRONT, 32'h8000_0000);
        send_action(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        send_action(ACT_PUSH_FRONT, 32'h1234_5678);
        send_action(ACT_PUSH_BACK, 32'hFEDC_BA98);
        repeat (4) send_action(ACT_POP_FRONT, $urandom());
        repeat (4) send_action(ACT_POP_BACK, $urandom());
        send_action(ACT_POP_FRONT, $urandom());

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: push_bias = 15;
                    1: push_bias = 50;
                    default: push_bias = 85;
                endcase
                case ($urandom_range(2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if ($urandom_range(99) < push_bias)
                act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            send_action(act, pick_value());
        end
        s_tvalid <= 1'b0;

        drain_cycles = 0;
        while (results_pending != 0 && drain_cycles < 2000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (results_pending == 0 && mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
